### src/lcdns_pkg.sv
// Package: types, codes and the init action table of the LCD nibble sequencer.
`timescale 1ns / 1ps
`default_nettype none
package lcdns_pkg;

   localparam int INIT_LEN    = 21;
   localparam int STEP_W      = $clog2(INIT_LEN);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] CMD_INIT       = 3'd0;
   localparam logic [2:0] CMD_CHAR_POLL  = 3'd1;
   localparam logic [2:0] CMD_STREAM     = 3'd2;
   localparam logic [2:0] CMD_GOTO       = 3'd3;
   localparam logic [2:0] CMD_CLEAR      = 3'd4;
   localparam logic [2:0] CMD_CURSOR_ON  = 3'd5;
   localparam logic [2:0] CMD_CURSOR_OFF = 3'd6;
   localparam logic [2:0] CMD_RESERVED   = 3'd7;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_WAIT  = 2'd1;
   localparam logic [1:0] ACT_POLL  = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   localparam logic       RS_INSTR = 1'b0;
   localparam logic       RS_DATA  = 1'b1;

   localparam logic [7:0] BYTE_CLEAR      = 8'h01;
   localparam logic [7:0] BYTE_CURSOR_ON  = 8'h0F;
   localparam logic [7:0] BYTE_CURSOR_OFF = 8'h0C;
   localparam logic [6:0] ROW2_BASE       = 7'h40;
   localparam logic [6:0] ROW3_BASE       = 7'h14;
   localparam logic [6:0] ROW4_BASE       = 7'h54;
   localparam logic       DDRAM_SET       = 1'b1;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data_byte;
      logic [6:0] column;
      logic [2:0] row;
   } req_type;

   typedef struct packed {
      logic [1:0] action_kind;
      logic       reg_select;
      logic [3:0] nibble;
      logic [3:0] wait_ms;
      logic       last_action;
   } rsp_type;

   typedef enum logic [1:0] {
      SEQ_INIT      = 2'd0,
      SEQ_BYTE_POLL = 2'd1,
      SEQ_BYTE      = 2'd2,
      SEQ_POLL_BYTE = 2'd3
   } seq_type;

   typedef struct packed {
      seq_type    seq;
      logic       reg_select;
      logic [7:0] byte_val;
   } desc_type;

   function automatic rsp_type mk_act(logic [1:0] kind, logic [3:0] nib, logic [3:0] ms);
      rsp_type a;
      a.action_kind = kind;
      a.reg_select  = RS_INSTR;
      a.nibble      = nib;
      a.wait_ms     = ms;
      a.last_action = 1'b0;
      return a;
   endfunction

   function automatic rsp_type init_action(logic [STEP_W-1:0] step);
      rsp_type a;
      a = mk_act(ACT_NONE, 4'h0, 4'h0);
      unique case (step)
         5'd0:    a = mk_act(ACT_WAIT,  4'h0, 4'd15);
         5'd1:    a = mk_act(ACT_WRITE, 4'h3, 4'd0);
         5'd2:    a = mk_act(ACT_WAIT,  4'h0, 4'd5);
         5'd3:    a = mk_act(ACT_WRITE, 4'h3, 4'd0);
         5'd4:    a = mk_act(ACT_WAIT,  4'h0, 4'd1);
         5'd5:    a = mk_act(ACT_WRITE, 4'h3, 4'd0);
         5'd6:    a = mk_act(ACT_WAIT,  4'h0, 4'd1);
         5'd7:    a = mk_act(ACT_WRITE, 4'h2, 4'd0);
         5'd8:    a = mk_act(ACT_WAIT,  4'h0, 4'd1);
         5'd9:    a = mk_act(ACT_WRITE, 4'h2, 4'd0);
         5'd10:   a = mk_act(ACT_WRITE, 4'h8, 4'd0);
         5'd11:   a = mk_act(ACT_POLL,  4'h0, 4'd0);
         5'd12:   a = mk_act(ACT_WRITE, 4'h0, 4'd0);
         5'd13:   a = mk_act(ACT_WRITE, 4'hC, 4'd0);
         5'd14:   a = mk_act(ACT_POLL,  4'h0, 4'd0);
         5'd15:   a = mk_act(ACT_WRITE, 4'h0, 4'd0);
         5'd16:   a = mk_act(ACT_WRITE, 4'h1, 4'd0);
         5'd17:   a = mk_act(ACT_POLL,  4'h0, 4'd0);
         5'd18:   a = mk_act(ACT_WRITE, 4'h0, 4'd0);
         5'd19:   a = mk_act(ACT_WRITE, 4'h6, 4'd0);
         5'd20:   a = mk_act(ACT_POLL,  4'h0, 4'd0);
         default: a = mk_act(ACT_NONE,  4'h0, 4'd0);
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

### src/lcdns_front.sv
// Front end: request transfer, command classification and goto address build.
`timescale 1ns / 1ps
`default_nettype none
module lcdns_front (
   input  wire logic               start,
   output logic                    busy,
   input  wire lcdns_pkg::req_type req_payload,
   input  wire logic               q_full,
   output logic                    q_push,
   output lcdns_pkg::desc_type     q_desc
);
   import lcdns_pkg::*;

   logic [6:0] row_base;
   logic [6:0] goto_addr;
   logic       keep;

   always_comb begin
      unique case (req_payload.row)
         3'd2:    row_base = ROW2_BASE;
         3'd3:    row_base = ROW3_BASE;
         3'd4:    row_base = ROW4_BASE;
         default: row_base = 7'h00;
      endcase
   end

   assign goto_addr = row_base + req_payload.column - 7'd1;

   always_comb begin
      keep              = 1'b1;
      q_desc.seq        = SEQ_BYTE;
      q_desc.reg_select = RS_INSTR;
      q_desc.byte_val   = req_payload.data_byte;
      unique case (req_payload.command)
         CMD_INIT: begin
            q_desc.seq = SEQ_INIT;
         end
         CMD_CHAR_POLL: begin
            q_desc.seq        = SEQ_BYTE_POLL;
            q_desc.reg_select = RS_DATA;
         end
         CMD_STREAM: begin
            q_desc.reg_select = RS_DATA;
         end
         CMD_GOTO: begin
            q_desc.seq      = SEQ_POLL_BYTE;
            q_desc.byte_val = {DDRAM_SET, goto_addr};
         end
         CMD_CLEAR:      q_desc.byte_val = BYTE_CLEAR;
         CMD_CURSOR_ON:  q_desc.byte_val = BYTE_CURSOR_ON;
         CMD_CURSOR_OFF: q_desc.byte_val = BYTE_CURSOR_OFF;
         CMD_RESERVED:   keep = 1'b0;
         default:        keep = 1'b0;
      endcase
   end

   assign busy   = q_full;
   assign q_push = start && !q_full && keep;

endmodule
`default_nettype wire

### src/lcdns_queue.sv
// Short descriptor queue between the front end and the action sequencer.
`timescale 1ns / 1ps
`default_nettype none
module lcdns_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire lcdns_pkg::desc_type push_desc,
   input  wire logic                pop,
   output logic                     full,
   output logic                     empty,
   output lcdns_pkg::desc_type      head_desc
);
   import lcdns_pkg::*;

   desc_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_desc = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### src/lcdns_back.sv
// Back end: steps through one descriptor's bus actions, one action a cycle.
`timescale 1ns / 1ps
`default_nettype none
module lcdns_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire lcdns_pkg::desc_type q_desc,
   output logic                     q_pop,
   output logic                     rsp_strobe,
   output lcdns_pkg::rsp_type       rsp_payload
);
   import lcdns_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   desc_type            cur_ff,   cur_in;
   logic [STEP_W-1:0]   step_ff,  step_in;
   logic                strobe_ff, strobe_in;
   rsp_type             act_ff,   act_in;
   logic [STEP_W-1:0]   last_step;
   logic                at_last;
   rsp_type             hi_act, lo_act, poll_act;

   always_comb begin
      unique case (cur_ff.seq)
         SEQ_INIT:      last_step = STEP_W'(INIT_LEN - 1);
         SEQ_BYTE_POLL: last_step = STEP_W'(2);
         SEQ_BYTE:      last_step = STEP_W'(1);
         SEQ_POLL_BYTE: last_step = STEP_W'(2);
         default:       last_step = STEP_W'(1);
      endcase
   end

   assign at_last = (step_ff == last_step);

   always_comb begin
      hi_act            = mk_act(ACT_WRITE, cur_ff.byte_val[7:4], 4'd0);
      hi_act.reg_select = cur_ff.reg_select;
      lo_act            = mk_act(ACT_WRITE, cur_ff.byte_val[3:0], 4'd0);
      lo_act.reg_select = cur_ff.reg_select;
      poll_act          = mk_act(ACT_POLL, 4'h0, 4'd0);
      unique case (cur_ff.seq)
         SEQ_INIT: act_in = init_action(step_ff);
         SEQ_BYTE_POLL, SEQ_BYTE: begin
            unique case (step_ff)
               STEP_W'(0): act_in = hi_act;
               STEP_W'(1): act_in = lo_act;
               default:    act_in = poll_act;
            endcase
         end
         SEQ_POLL_BYTE: begin
            unique case (step_ff)
               STEP_W'(0): act_in = poll_act;
               STEP_W'(1): act_in = hi_act;
               default:    act_in = lo_act;
            endcase
         end
         default: act_in = poll_act;
      endcase
      act_in.last_action = at_last;
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      step_in   = step_ff;
      q_pop     = 1'b0;
      strobe_in = (state_ff == ST_RUN);
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_desc;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!at_last) begin
               step_in = step_ff + 1'b1;
            end else if (!q_empty) begin
               q_pop   = 1'b1;
               cur_in  = q_desc;
               step_in = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      act_ff <= act_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = act_ff;

endmodule
`default_nettype wire

### src/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer.
//
//   channel   direction  transfer when        payload
//   request   in         start && !busy       req_payload (req_type)
//   result    out        rsp_strobe           rsp_payload (rsp_type)
//
// A request passes the queue, descriptor and action registers; then one action a
// cycle: 21 for init, 3 for char+poll and goto, 2 for stream char, clear and cursor.
// The action sequencer sets the rate; the next queued request follows without a gap.
// Two requests queue; busy rises while the queue is full. Reserved commands are dropped.
// Reset clears the queue and the sequencer; results cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_nibble_sequencer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire lcdns_pkg::req_type req_payload,
   output logic                    rsp_strobe,
   output lcdns_pkg::rsp_type      rsp_payload
);
   import lcdns_pkg::*;

   logic     q_full, q_empty, q_push, q_pop;
   desc_type push_desc, head_desc;

   lcdns_front u_front (
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_desc      (push_desc)
   );

   lcdns_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_desc (head_desc)
   );

   lcdns_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_desc      (head_desc),
      .q_pop       (q_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   a_no_strobe_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe directly after reset");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.action_kind != ACT_NONE))
      else $error("undefined action kind on result");

   a_clean_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.action_kind != ACT_WRITE) |->
         (rsp_payload.nibble == 4'h0 && rsp_payload.reg_select == RS_INSTR))
      else $error("wait or poll action carries bus data");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("queue push while full");

endmodule
`default_nettype wire
